>>> src/cpdp_pkg.sv
// Shared types, codes and constants of the current pattern DAC player.
`timescale 1ns / 1ps

package cpdp_pkg;

    // Storage and field widths
    localparam int P_PATTERN_DEPTH = 1024;
    localparam int WORD_W          = 16;
    localparam int CMP_W           = 17;   // holds any length or position up to 65536
    localparam int NUM_W           = 33;   // dividend of the code conversion
    localparam int DEN_W           = 17;   // divisor of the code conversion
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    // Defaults selected by a zero register
    localparam logic [15:0] DEFAULT_STEP_UA = 16'd20;
    localparam logic [15:0] DEFAULT_FS_UA   = 16'd1250;

    // Action codes of an input item
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_FAULT = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 3'd4;

    // Finish reasons
    localparam logic [1:0] RSN_COMPLETED = 2'd0;
    localparam logic [1:0] RSN_STOPPED   = 2'd1;
    localparam logic [1:0] RSN_ERROR     = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [9:0]         load_index;
        logic signed [15:0] load_value;
    } t_in;

    typedef struct packed {
        logic [15:0] dac_code;
        logic        drive;
        logic        status;
        logic        active;
        logic        done_res;
        logic [1:0]  fin_reason;
        logic        last;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic       mem_write;    // store the load word of the accepted item
        logic       tick_step;    // read the current word and advance playback
        logic       start;        // start playback if length and repeats allow
        logic       halt;         // end playback with halt_reason
        logic [1:0] halt_reason;
        logic       src_idle;     // convert the idle level instead of the word
        logic       mul_load;
        logic       clamp_load;
        logic       div_start;
        logic       out_load;
        logic       out_code;     // result carries a converted code
        logic       out_status;
        logic       out_done;
        logic       out_last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic playing;
        logic len_zero;
        logic start_bad;
        logic tick_fin;    // the tick now pending ends the last pass
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage

>>> src/cpdp_div.sv
// Bit-serial restoring divider for the DAC code scaling.
`timescale 1ns / 1ps

module cpdp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cpdp_pkg::NUM_W-1:0]   i_num,
    input  logic [cpdp_pkg::DEN_W-1:0]   i_den,
    output logic                         o_busy,
    output logic [cpdp_pkg::WORD_W-1:0]  o_quo
);

    localparam int NW    = cpdp_pkg::NUM_W;
    localparam int DW    = cpdp_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [NW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DW:0]      w_rem_sh;
    logic [DW:0]      w_diff;
    logic             w_ge;

    // Shift in the next dividend bit and try the subtraction
    assign w_rem_sh = {r_rem, r_quo[NW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    // One quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NW);
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            r_quo  <= {r_quo[NW-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo[cpdp_pkg::WORD_W-1:0];

endmodule

>>> src/cpdp_dp.sv
// Datapath: registers, pattern memory, playback state, code conversion, result register.
`timescale 1ns / 1ps

module cpdp_dp #(
    parameter int PATTERN_DEPTH = cpdp_pkg::P_PATTERN_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cpdp_pkg::t_in                      i_in,
    input  cpdp_pkg::t_dp_cmd                  i_cmd,
    output cpdp_pkg::t_dp_sts                  o_sts,
    input  logic                               i_cfg_we,
    input  logic [cpdp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cpdp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output cpdp_pkg::t_out                     o_out
);

    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int CW = cpdp_pkg::CMP_W;
    localparam int WW = cpdp_pkg::WORD_W;
    localparam int NW = cpdp_pkg::NUM_W;
    localparam int DW = cpdp_pkg::DEN_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(PATTERN_DEPTH);

    // Configuration registers
    logic [15:0]        r_step;
    logic [15:0]        r_fs;
    logic signed [15:0] r_idle;
    logic [10:0]        r_len;
    logic [31:0]        r_rep;

    // Playback state
    logic [AW-1:0]      r_pos;
    logic [31:0]        r_passes;
    logic               r_playing;
    logic [1:0]         r_reason;

    // Pattern memory and read register
    logic [WW-1:0]      r_mem [PATTERN_DEPTH];
    logic [WW-1:0]      r_rd_data;

    // Conversion pipeline
    logic signed [32:0] r_prod;
    logic [DW-1:0]      r_shift;

    // Result register
    logic               r_out_valid;
    cpdp_pkg::t_out     r_out;

    logic [15:0]        w_step_eff;
    logic [15:0]        w_fs_eff;
    logic [CW-1:0]      w_len_eff;
    logic [CW-1:0]      w_pos_inc;
    logic               w_wrap;
    logic [CW-1:0]      w_load_idx;
    logic signed [15:0] w_src;
    logic signed [16:0] w_step_s;
    logic signed [32:0] w_prod;
    logic signed [33:0] w_prod_x;
    logic signed [33:0] w_fs_x;
    logic signed [33:0] w_clamped;
    logic signed [33:0] w_shifted;
    logic [NW-1:0]      w_num;
    logic [DW-1:0]      w_den;
    logic               w_div_busy;
    logic [WW-1:0]      w_quo;
    logic               w_start_bad;

    // Effective settings
    assign w_step_eff  = (r_step == '0) ? cpdp_pkg::DEFAULT_STEP_UA : r_step;
    assign w_fs_eff    = (r_fs == '0) ? cpdp_pkg::DEFAULT_FS_UA : r_fs;
    assign w_len_eff   = (CW'(r_len) > DEPTH_C) ? DEPTH_C : CW'(r_len);
    assign w_pos_inc   = CW'(r_pos) + 1'b1;
    assign w_wrap      = (w_pos_inc >= w_len_eff);
    assign w_load_idx  = CW'(i_in.load_index);
    assign w_start_bad = (r_len == '0) || (r_rep == '0);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= cpdp_pkg::DEFAULT_STEP_UA;
            r_fs   <= cpdp_pkg::DEFAULT_FS_UA;
            r_idle <= '0;
            r_len  <= '0;
            r_rep  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cpdp_pkg::REG_STEP:   r_step <= i_cfg_data[15:0];
                cpdp_pkg::REG_FS:     r_fs   <= i_cfg_data[15:0];
                cpdp_pkg::REG_IDLE:   r_idle <= i_cfg_data[15:0];
                cpdp_pkg::REG_LENGTH: r_len  <= i_cfg_data[10:0];
                cpdp_pkg::REG_REPEAT: r_rep  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Store load words, fetch the word at the play position
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && (w_load_idx < DEPTH_C)) begin
            r_mem[w_load_idx[AW-1:0]] <= i_in.load_value;
        end
        if (i_cmd.tick_step) begin
            r_rd_data <= r_mem[r_pos];
        end
    end

    // Advance, start and halt playback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_passes  <= '0;
            r_playing <= 1'b0;
            r_reason  <= cpdp_pkg::RSN_COMPLETED;
        end else if (i_cmd.tick_step) begin
            if (w_wrap) begin
                r_pos <= '0;
                if (r_passes != '0) begin
                    r_passes <= r_passes - 1'b1;
                end
                if (r_passes <= 32'd1) begin
                    r_playing <= 1'b0;
                    r_reason  <= cpdp_pkg::RSN_COMPLETED;
                end
            end else begin
                r_pos <= w_pos_inc[AW-1:0];
            end
        end else if (i_cmd.start) begin
            if (!w_start_bad) begin
                r_pos     <= '0;
                r_passes  <= r_rep;
                r_playing <= 1'b1;
                r_reason  <= cpdp_pkg::RSN_COMPLETED;
            end
        end else if (i_cmd.halt) begin
            r_playing <= 1'b0;
            r_reason  <= i_cmd.halt_reason;
        end
    end

    // Scale the code by the current step
    assign w_src    = i_cmd.src_idle ? r_idle : $signed(r_rd_data);
    assign w_step_s = $signed({1'b0, w_step_eff});
    assign w_prod   = w_src * w_step_s;

    // Clamp to plus or minus full scale and offset by full scale
    assign w_prod_x  = {r_prod[32], r_prod};
    assign w_fs_x    = $signed({18'd0, w_fs_eff});
    assign w_clamped = (w_prod_x > w_fs_x)  ? w_fs_x :
                       (w_prod_x < -w_fs_x) ? -w_fs_x : w_prod_x;
    assign w_shifted = w_clamped + w_fs_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_prod <= w_prod;
        end
        if (i_cmd.clamp_load) begin
            r_shift <= w_shifted[DW-1:0];
        end
    end

    // Rounded scaling: (shift * 65535 + fs) / (2 * fs)
    assign w_num = {r_shift, 16'd0} - NW'(r_shift) + NW'(w_fs_eff);
    assign w_den = {w_fs_eff, 1'b0};

    cpdp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Hold the result until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.dac_code    <= i_cmd.out_code ? w_quo : '0;
            r_out.drive       <= i_cmd.out_code;
            r_out.status      <= i_cmd.out_status;
            r_out.active      <= r_playing;
            r_out.done_res    <= i_cmd.out_done;
            r_out.fin_reason  <= r_reason;
            r_out.last        <= i_cmd.out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

    assign o_sts.playing   = r_playing;
    assign o_sts.len_zero  = (w_len_eff == '0);
    assign o_sts.start_bad = w_start_bad;
    assign o_sts.tick_fin  = w_wrap && (r_passes <= 32'd1);
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

>>> src/cpdp_ctrl.sv
// Controller: decodes each item and sequences conversion and result delivery.
`timescale 1ns / 1ps

module cpdp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_action,
    input  cpdp_pkg::t_dp_sts    i_sts,
    output cpdp_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_CLAMP  = 6'b000100,
        S_DIVGO  = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_src_idle, n_src_idle;
    logic   r_code, n_code;
    logic   r_status, n_status;
    logic   r_done, n_done;
    logic   r_last, n_last;
    logic   r_second, n_second;
    logic   w_accept;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_src_idle = r_src_idle;
        n_code     = r_code;
        n_status   = r_status;
        n_done     = r_done;
        n_last     = r_last;
        n_second   = r_second;
        o_cmd             = '0;
        o_cmd.halt_reason = cpdp_pkg::RSN_STOPPED;
        o_cmd.src_idle    = r_src_idle;
        o_cmd.out_code    = r_code;
        o_cmd.out_status  = r_status;
        o_cmd.out_done    = r_done;
        o_cmd.out_last    = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        cpdp_pkg::ACT_TICK: begin
                            if (i_sts.playing && !i_sts.len_zero) begin
                                o_cmd.tick_step = 1'b1;
                                n_state    = S_MUL;
                                n_src_idle = 1'b0;
                                n_code     = 1'b1;
                                n_status   = 1'b0;
                                n_done     = 1'b0;
                                n_last     = !i_sts.tick_fin;
                                n_second   = i_sts.tick_fin;
                            end
                        end
                        cpdp_pkg::ACT_LOAD: begin
                            o_cmd.mem_write = 1'b1;
                        end
                        cpdp_pkg::ACT_START: begin
                            o_cmd.start = 1'b1;
                            n_state  = S_EMIT;
                            n_code   = 1'b0;
                            n_status = i_sts.start_bad;
                            n_done   = 1'b0;
                            n_last   = 1'b1;
                            n_second = 1'b0;
                        end
                        cpdp_pkg::ACT_STOP: begin
                            o_cmd.halt        = 1'b1;
                            o_cmd.halt_reason = cpdp_pkg::RSN_STOPPED;
                            n_state    = S_MUL;
                            n_src_idle = 1'b1;
                            n_code     = 1'b1;
                            n_status   = 1'b0;
                            n_done     = 1'b0;
                            n_last     = 1'b1;
                            n_second   = 1'b0;
                        end
                        cpdp_pkg::ACT_FAULT: begin
                            o_cmd.halt        = 1'b1;
                            o_cmd.halt_reason = cpdp_pkg::RSN_ERROR;
                            n_state    = S_MUL;
                            n_src_idle = 1'b1;
                            n_code     = 1'b1;
                            n_status   = 1'b0;
                            n_done     = 1'b1;
                            n_last     = 1'b1;
                            n_second   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp_load = 1'b1;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    // After the final word, convert the idle level for the done result
                    if (r_second) begin
                        n_state    = S_MUL;
                        n_src_idle = 1'b1;
                        n_code     = 1'b1;
                        n_status   = 1'b0;
                        n_done     = 1'b1;
                        n_last     = 1'b1;
                        n_second   = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src_idle <= n_src_idle;
        r_code     <= n_code;
        r_status   <= n_status;
        r_done     <= n_done;
        r_last     <= n_last;
    end

endmodule

>>> src/current_pattern_dac_player_top.sv
// Top level of the current pattern DAC player.
`timescale 1ns / 1ps

// Plays a stored pattern of signed current codes to a 16-bit current DAC.
// Load items fill the pattern memory, start begins playback, and each tick
// while playing yields one DAC code: word times current step, clamped to
// plus or minus full scale, offset and scaled with rounding to 0..65535.
// Items are handled one at a time. Loads, unused codes, starts and ticks
// with nothing to play need no conversion; a tick that plays a word, a
// stop and a fault each run the 33-step bit-serial divider that does the
// rounded scaling; the tick that ends the final pass runs the divider
// twice (word and idle code). A stalled output holds the next result
// back. A finished result waits in the output register while the
// next item is taken. Pattern words must be loaded before they are played.
module current_pattern_dac_player_top #(
    parameter int PATTERN_DEPTH = cpdp_pkg::P_PATTERN_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  cpdp_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output cpdp_pkg::t_out                     o_out,
    input  logic                               i_cfg_we,
    input  logic [cpdp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cpdp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    cpdp_pkg::t_dp_cmd w_cmd;
    cpdp_pkg::t_dp_sts w_sts;

    cpdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_action   (i_in.action),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cpdp_dp #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> src/cpdp_chk.sv
// Port checker for the current pattern DAC player, bound to the top level.
`timescale 1ns / 1ps

module cpdp_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input cpdp_pkg::t_in   i_in,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input cpdp_pkg::t_out  o_out
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("stalled result changed");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // Start, stop and fault always stall the input in the cycle after they are taken
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (i_in.action == cpdp_pkg::ACT_START || i_in.action == cpdp_pkg::ACT_STOP ||
         i_in.action == cpdp_pkg::ACT_FAULT) |=> o_in_stall)
        else $error("input taken while a result is being made");

    // A done result drives the idle code, ends the item and leaves playback off
    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> o_out.last && o_out.drive && !o_out.active)
        else $error("malformed done result");

endmodule

bind current_pattern_dac_player_top cpdp_chk u_chk (.*);
